### src/assert_macros.svh
// Assertion macros used by the frame deframer datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

### src/flfd_pkg.sv
// Types and constants of the fixed-length frame deframer.
package flfd_pkg;

   localparam int BYTE_W     = 8;
   localparam int IDX_W      = 7;
   localparam int END_W      = 6;
   localparam int HDR_LEN    = 5;
   localparam int HDR_IDX_W  = 3;
   localparam int CSR_IDX_W  = 1;

   localparam logic [BYTE_W-1:0] START_MARK  = 8'h3E;
   localparam logic [BYTE_W-1:0] SHORT_FIRST = 8'h30;
   localparam logic [IDX_W-1:0]  INDEX_WRAP  = 7'd90;

   localparam logic [END_W-1:0] LONG_END_RESET  = 6'd51;
   localparam logic [END_W-1:0] SHORT_END_RESET = 6'd24;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_END  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_END = 1'b1;

   // frame kinds
   localparam logic KIND_LONG  = 1'b0;
   localparam logic KIND_SHORT = 1'b1;

   typedef logic [HDR_LEN-1:0][BYTE_W-1:0] hdr_type;

   // ">PULT" and ">Bom@", entry 0 in the low byte
   localparam hdr_type HDR_LONG  = {8'h54, 8'h4C, 8'h55, 8'h50, 8'h3E};
   localparam hdr_type HDR_SHORT = {8'h40, 8'h6D, 8'h6F, 8'h42, 8'h3E};

   typedef struct packed {
      logic accept_wr;   // store the accepted request byte at the write index
      logic mark_wr;     // store the start mark at entry 0, index to 1
      logic idx_step;    // advance the write index with wrap
      logic emit_start;  // latch frame kind and length, rewind read pointer
      logic rd_issue;    // read next frame entry into the output register
      logic out_drop;    // empty the output register
      logic frame_clear; // clear the store, index to 1
   } cmd_type;

   typedef struct packed {
      logic mark;        // last accepted byte was the start mark
      logic long_hit;    // long frame complete
      logic short_hit;   // short frame complete
      logic rd_more;     // frame entries left to read
      logic out_valid;   // output register holds a byte
   } sts_type;

endpackage

### src/flfd_ifs.sv
// Request and response channel interfaces of the frame deframer.
interface flfd_req_if;
   import flfd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              rx_error;
   modport source (output valid, rx_byte, rx_error, input ready);
   modport sink   (input valid, rx_byte, rx_error, output ready);
endinterface

interface flfd_rsp_if;
   import flfd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] frame_byte;
   logic              frame_kind;
   logic              last;
   modport source (output valid, frame_byte, frame_kind, last, input ready);
   modport sink   (input valid, frame_byte, frame_kind, last, output ready);
endinterface

### src/flfd_csr.sv
// Frame end registers of the frame deframer.
module flfd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [flfd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [flfd_pkg::END_W-1:0]         csr_wdata,
   output logic [flfd_pkg::END_W-1:0]         long_end,
   output logic [flfd_pkg::END_W-1:0]         short_end
);
   import flfd_pkg::*;

   logic [END_W-1:0] long_end_ff, long_end_in;
   logic [END_W-1:0] short_end_ff, short_end_in;

   // decode the write
   always_comb begin
      long_end_in  = long_end_ff;
      short_end_in = short_end_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LONG_END:  long_end_in  = csr_wdata;
            CSR_SHORT_END: short_end_in = csr_wdata;
            default: begin
               long_end_in  = long_end_ff;
               short_end_in = short_end_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_end_ff  <= LONG_END_RESET;
         short_end_ff <= SHORT_END_RESET;
      end else begin
         long_end_ff  <= long_end_in;
         short_end_ff <= short_end_in;
      end
   end

   assign long_end  = long_end_ff;
   assign short_end = short_end_ff;

endmodule

### src/flfd_ctrl.sv
// Controller state machine of the frame deframer.
module flfd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_error,
   output logic              req_ready,
   input  logic              rsp_ready,
   input  flfd_pkg::sts_type sts,
   output flfd_pkg::cmd_type cmd
);
   import flfd_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       advance;

   // output register can take a new byte
   assign advance = !sts.out_valid || rsp_ready;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         ST_IDLE: begin
            // take a request; drop errored bytes on the spot
            req_ready = 1'b1;
            if (req_valid && !req_error) begin
               cmd.accept_wr = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.mark) begin
               cmd.mark_wr = 1'b1;
               state_in    = ST_IDLE;
            end else if (sts.long_hit || sts.short_hit) begin
               cmd.emit_start = 1'b1;
               state_in       = ST_EMIT;
            end else begin
               cmd.idx_step = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_EMIT: begin
            // stream one byte per cycle, hold while the consumer stalls
            if (advance) begin
               if (sts.rd_more) begin
                  cmd.rd_issue = 1'b1;
               end else begin
                  cmd.out_drop    = 1'b1;
                  cmd.frame_clear = 1'b1;
                  state_in        = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/flfd_dp.sv
// Datapath of the frame deframer: frame store, header, index and output register.
`include "assert_macros.svh"

module flfd_dp #(
   parameter int STORE_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  flfd_pkg::cmd_type             cmd,
   output flfd_pkg::sts_type             sts,
   input  logic [flfd_pkg::BYTE_W-1:0]   req_byte,
   input  logic [flfd_pkg::END_W-1:0]    long_end,
   input  logic [flfd_pkg::END_W-1:0]    short_end,
   output logic                          rsp_valid,
   output logic [flfd_pkg::BYTE_W-1:0]   rsp_frame_byte,
   output logic                          rsp_frame_kind,
   output logic                          rsp_last
);
   import flfd_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);
   localparam logic [IDX_W:0] DEPTH_L = (IDX_W + 1)'(STORE_DEPTH);

   // frame store, no reset: entry valid bits stand in for the zero fill
   logic [BYTE_W-1:0]      mem [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] entry_valid_ff, entry_valid_in;

   hdr_type           hdr_ff, hdr_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              mark_ff;
   logic              kind_ff;
   logic [IDX_W-1:0]  k_ff;
   logic [END_W-1:0]  end_ff;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] data_ff;
   logic              zero_ff;
   logic              sub_ff;
   logic              last_ff;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [BYTE_W-1:0] mem_wdata;
   logic              idx_in_range;
   logic              k_in_range;
   logic              rd_entry_valid;

   assign idx_in_range = {1'b0, idx_ff} < DEPTH_L;
   assign k_in_range   = {1'b0, k_ff} < DEPTH_L;

   // select the store write: request byte at the index, or the start mark at entry 0
   assign mem_we    = (cmd.accept_wr && idx_in_range) || cmd.mark_wr;
   assign mem_waddr = cmd.mark_wr ? AW'(0) : idx_ff[AW-1:0];
   assign mem_wdata = cmd.mark_wr ? START_MARK : req_byte;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.rd_issue) begin
         data_ff <= mem[k_ff[AW-1:0]];
      end
   end

   // track written entries; a frame clears them all
   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (cmd.frame_clear) begin
         entry_valid_in = '0;
      end else if (mem_we) begin
         entry_valid_in[mem_waddr] = 1'b1;
      end
   end

   // mirror of the first entries for the header compare
   always_comb begin
      hdr_in = hdr_ff;
      if (cmd.frame_clear) begin
         hdr_in = '0;
      end else if (cmd.mark_wr) begin
         hdr_in[0] = START_MARK;
      end else if (cmd.accept_wr && idx_ff < IDX_W'(HDR_LEN)) begin
         hdr_in[idx_ff[HDR_IDX_W-1:0]] = req_byte;
      end
   end

   // advance the write index
   always_comb begin
      idx_in = idx_ff;
      if (cmd.mark_wr || cmd.frame_clear) begin
         idx_in = IDX_W'(1);
      end else if (cmd.idx_step) begin
         idx_in = (idx_ff == INDEX_WRAP) ? '0 : idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.rd_issue) begin
         out_valid_in = 1'b1;
      end else if (cmd.out_drop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         hdr_ff         <= '0;
         idx_ff         <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         hdr_ff         <= hdr_in;
         idx_ff         <= idx_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   assign rd_entry_valid = k_in_range ? entry_valid_ff[k_ff[AW-1:0]] : 1'b0;

   // request flags, frame length and output payload
   always_ff @(posedge clock) begin
      if (cmd.accept_wr) begin
         mark_ff <= (req_byte == START_MARK);
      end
      if (cmd.emit_start) begin
         kind_ff <= sts.long_hit ? KIND_LONG : KIND_SHORT;
         k_ff    <= '0;
         end_ff  <= idx_ff[END_W-1:0];
      end else if (cmd.rd_issue) begin
         k_ff <= k_ff + IDX_W'(1);
      end
      if (cmd.rd_issue) begin
         zero_ff <= !rd_entry_valid;
         sub_ff  <= (k_ff == '0) && (kind_ff == KIND_SHORT);
         last_ff <= (k_ff == {1'b0, end_ff});
      end
   end

   // status to the controller
   always_comb begin
      sts.mark      = mark_ff;
      sts.long_hit  = (idx_ff == {1'b0, long_end}) && (hdr_ff == HDR_LONG);
      sts.short_hit = (idx_ff == {1'b0, short_end}) && (hdr_ff == HDR_SHORT);
      sts.rd_more   = k_ff <= {1'b0, end_ff};
      sts.out_valid = out_valid_ff;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_frame_byte = sub_ff ? SHORT_FIRST : (zero_ff ? '0 : data_ff);
   assign rsp_frame_kind = kind_ff;
   assign rsp_last       = last_ff;

   `ASSERT_NEXT(a_clear_restarts_index, cmd.frame_clear, idx_ff == IDX_W'(1), "index not 1 after frame")
   `ASSERT_CLK(a_last_ends_reads, !(out_valid_ff && last_ff) || !sts.rd_more, "bytes left after last")
   `ASSERT_CLK(a_no_store_while_emit, !(out_valid_ff && cmd.accept_wr), "request taken during frame output")

endmodule

### src/fixed_length_frame_deframer.sv
// Top level of the fixed-length frame deframer.
// Takes one received byte per request and answers with the bytes of a completed frame.
// A request that stores a byte and completes no frame passes the accept state, then
// the index update or header check; an errored byte is dropped in its accept cycle. A
// request that completes a frame of end index E sends entries 0 to E: the frame store
// has one read port, so the frame leaves one byte per cycle while the consumer does
// not stall, and a final step clears the store. The next request is taken after
// that. The store clears by valid bits; reset needs no clearing pass.
module fixed_length_frame_deframer #(
   parameter int STORE_DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   flfd_req_if.sink                        req_ch,
   flfd_rsp_if.source                      rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [flfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [flfd_pkg::END_W-1:0]      csr_wdata
);
   import flfd_pkg::*;

   cmd_type          cmd;
   sts_type          sts;
   logic [END_W-1:0] long_end;
   logic [END_W-1:0] short_end;

   flfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .long_end  (long_end),
      .short_end (short_end)
   );

   flfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_error (req_ch.rx_error),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   flfd_dp #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_byte       (req_ch.rx_byte),
      .long_end       (long_end),
      .short_end      (short_end),
      .rsp_valid      (rsp_ch.valid),
      .rsp_frame_byte (rsp_ch.frame_byte),
      .rsp_frame_kind (rsp_ch.frame_kind),
      .rsp_last       (rsp_ch.last)
   );

endmodule

### tb/tb_top.sv
// Self-checking testbench for the fixed-length frame deframer.
`timescale 1ns / 1ps

module tb_top;
   import flfd_pkg::*;

   localparam int STORE_DEPTH    = 64;
   localparam int CLK_PERIOD     = 10;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RUNAWAY_LEN    = 92;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic              frame_kind;
      logic              last;
   } frame_beat_type;

   // quiet: the request must produce no frame byte
   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              rx_error;
      logic              quiet;
   } dir_row_type;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_type;

   // Directed part, run with both frame ends at 5.
   localparam int DIR_ROWS = 21;
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      '{8'h00, 1'b0, 1'b1},   // lowest byte at index 0
      '{8'hFF, 1'b1, 1'b1},   // errored bytes are dropped
      '{8'h3E, 1'b1, 1'b1},   // errored start mark does not restart
      '{8'h3E, 1'b0, 1'b1},
      '{8'h50, 1'b0, 1'b1},
      '{8'hFF, 1'b1, 1'b1},
      '{8'h55, 1'b0, 1'b1},
      '{8'h4C, 1'b0, 1'b1},
      '{8'h54, 1'b0, 1'b1},
      '{8'hFF, 1'b0, 1'b0},   // long frame completes at end index 5
      '{8'h3E, 1'b0, 1'b1},
      '{8'h42, 1'b0, 1'b1},
      '{8'h6F, 1'b0, 1'b1},
      '{8'h3E, 1'b0, 1'b1},   // start mark mid-frame restarts
      '{8'h42, 1'b0, 1'b1},
      '{8'h6F, 1'b0, 1'b1},
      '{8'h6D, 1'b0, 1'b1},
      '{8'h40, 1'b0, 1'b1},
      '{8'h00, 1'b0, 1'b0},   // short frame, entry 0 sent as '0'
      '{8'h41, 1'b0, 1'b1},
      '{8'h80, 1'b1, 1'b1}
   };

   logic clock = 1'b0;
   logic reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [END_W-1:0]     csr_wdata;

   flfd_req_if req_ch();
   flfd_rsp_if rsp_ch();

   fixed_length_frame_deframer #(.STORE_DEPTH(STORE_DEPTH)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Deframer model state
   logic [BYTE_W-1:0] store_model [STORE_DEPTH];
   logic [IDX_W-1:0]  windex_model;
   logic [END_W-1:0]  long_end_model;
   logic [END_W-1:0]  short_end_model;

   frame_beat_type emitted[$];
   frame_beat_type frame_bytes_due[$];

   int mismatches     = 0;
   int good_sent      = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_token     = 0;

   function automatic logic [BYTE_W-1:0] store_peek(input int unsigned k);
      return (k < STORE_DEPTH) ? store_model[k] : '0;
   endfunction

   function automatic bit header_matches(input hdr_type hdr);
      for (int k = 0; k < HDR_LEN; k++)
         if (store_peek(k) != hdr[k]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void clear_store();
      for (int k = 0; k < STORE_DEPTH; k++) store_model[k] = '0;
   endfunction

   // Emit entries 0..index, then clear the store.
   function automatic void emit_frame(input logic kind);
      frame_beat_type beat;
      for (int k = 0; k <= int'(windex_model); k++) begin
         beat.frame_byte = (k == 0 && kind == KIND_SHORT) ? SHORT_FIRST : store_peek(k);
         beat.frame_kind = kind;
         beat.last       = (k == int'(windex_model));
         emitted.push_back(beat);
      end
      clear_store();
      windex_model = '0;
   endfunction

   // Advance the model by one accepted request; frame bytes land in emitted.
   function automatic void deframe_byte(input logic [BYTE_W-1:0] b, input logic err);
      emitted.delete();
      if (err) return;
      if (windex_model < STORE_DEPTH) store_model[windex_model] = b;
      if (b == START_MARK) begin
         store_model[0] = START_MARK;
         windex_model   = 7'd1;
         return;
      end
      if (windex_model == {1'b0, long_end_model} && header_matches(HDR_LONG))
         emit_frame(KIND_LONG);
      else if (windex_model == {1'b0, short_end_model} && header_matches(HDR_SHORT))
         emit_frame(KIND_SHORT);
      windex_model = (windex_model >= INDEX_WRAP) ? '0 : windex_model + 7'd1;
   endfunction

   function automatic void check_frame_byte();
      frame_beat_type want;
      if (frame_bytes_due.size() == 0) begin
         $display("%0t: unexpected frame byte %h kind %0d last %0d", $time,
                  rsp_ch.frame_byte, rsp_ch.frame_kind, rsp_ch.last);
         mismatches++;
         return;
      end
      want = frame_bytes_due.pop_front();
      if (rsp_ch.frame_byte !== want.frame_byte) begin
         $display("%0t: frame_byte mismatch: expected %h, actual %h", $time,
                  want.frame_byte, rsp_ch.frame_byte);
         mismatches++;
      end
      if (rsp_ch.frame_kind !== want.frame_kind) begin
         $display("%0t: frame_kind mismatch: expected %0d, actual %0d", $time,
                  want.frame_kind, rsp_ch.frame_kind);
         mismatches++;
      end
      if (rsp_ch.last !== want.last) begin
         $display("%0t: last mismatch: expected %0d, actual %0d", $time,
                  want.last, rsp_ch.last);
         mismatches++;
      end
   endfunction

   function automatic void set_idling(input idling_type mode);
      send_idle_pct  = (mode == IDLE_SENDER   || mode == IDLE_BOTH) ?
                       ((mode == IDLE_BOTH) ? 29 : 79) : 0;
      recv_stall_pct = (mode == IDLE_RECEIVER || mode == IDLE_BOTH) ?
                       ((mode == IDLE_BOTH) ? 29 : 79) : 0;
   endfunction

   function automatic logic [BYTE_W-1:0] body_byte();
      logic [BYTE_W-1:0] b;
      do b = BYTE_W'($urandom_range(0, 255)); while (b == START_MARK);
      return b;
   endfunction

   // Offer one request, hold it until accepted, then update the model.
   task automatic send_request(input logic [BYTE_W-1:0] b, input logic err, input bit quiet);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.rx_byte  <= b;
      req_ch.rx_error <= err;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      deframe_byte(b, err);
      if (!quiet) foreach (emitted[i]) frame_bytes_due.push_back(emitted[i]);
      if (!err) good_sent++;
   endtask

   // Stop offering and wait until every frame byte has come back.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [END_W-1:0] long_end, input logic [END_W-1:0] short_end);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_LONG_END;
      csr_wdata <= long_end;
      @(posedge clock);
      csr_index <= CSR_SHORT_END;
      csr_wdata <= short_end;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      long_end_model  = long_end;
      short_end_model = short_end;
   endtask

   // Send a frame of the given kind; a broken one gets a bad header byte or a restart.
   task automatic send_frame(input logic kind, input bit broken);
      hdr_type           hdr;
      int unsigned       end_idx;
      int unsigned       bad_pos;
      logic [BYTE_W-1:0] b;
      hdr     = (kind == KIND_LONG) ? HDR_LONG : HDR_SHORT;
      end_idx = (kind == KIND_LONG) ? long_end_model : short_end_model;
      bad_pos = broken ? $urandom_range(1, end_idx) : end_idx + 1;
      for (int k = 0; k <= int'(end_idx); k++) begin
         b = (k < HDR_LEN) ? hdr[k] : body_byte();
         if (k == bad_pos)
            b = (k < HDR_LEN && $urandom_range(0, 1) == 1) ?
                b ^ BYTE_W'($urandom_range(1, 255)) : START_MARK;
         if ($urandom_range(0, 9) == 0)
            send_request(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b0);
         send_request(b, 1'b0, 1'b0);
      end
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 8);
      repeat (n)
         send_request(BYTE_W'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0), 1'b0);
   endtask

   // Random sequences until the phase has sent its share of good bytes.
   task automatic run_random(input int budget, input bit long_first, input bit runaway);
      int pick;
      good_sent = 0;
      if (long_first) send_frame(KIND_LONG, 1'b0);
      // no start mark for long enough to pass the store and wrap the index
      if (runaway) repeat (RUNAWAY_LEN) send_request(body_byte(), 1'b0, 1'b0);
      while (good_sent < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)      send_frame(1'($urandom_range(0, 1)), 1'b0);
         else if (pick < 85) send_frame(1'($urandom_range(0, 1)), 1'b1);
         else                send_noise();
         if ($urandom_range(0, 11) == 0) drain_results();
      end
   endtask

   // Receive side: check accepted frame bytes, drive ready.
   initial begin : rsp_side
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            check_frame_byte();
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Abort when nothing moves on either channel for too long.
   initial begin : watchdog
      int stuck_cycles;
      stuck_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset !== 1'b0 || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            stuck_cycles = 0;
         else
            stuck_cycles++;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request or frame byte accepted for %0d cycles", $time,
                     stuck_cycles);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin : stimulus
      req_ch.valid    <= 1'b0;
      req_ch.rx_byte  <= '0;
      req_ch.rx_error <= 1'b0;
      csr_wr_en       <= 1'b0;
      csr_index       <= CSR_LONG_END;
      csr_wdata       <= '0;
      reset           <= 1'b1;
      clear_store();
      windex_model    = '0;
      long_end_model  = LONG_END_RESET;
      short_end_model = SHORT_END_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed rows with both ends at 5
      configure(6'd5, 6'd5);
      set_idling(IDLE_NONE);
      for (int r = 0; r < DIR_ROWS; r++)
         send_request(DIRECTED[r].rx_byte, DIRECTED[r].rx_error, DIRECTED[r].quiet);
      drain_results();

      // no idling, but hold the receiver off long enough to back up the requests
      configure(6'd7, 6'd5);
      hold_token++;
      run_random(12, 1'b1, 1'b0);
      drain_results();

      configure(6'd5, 6'd9);
      set_idling(IDLE_SENDER);
      run_random(8, 1'b0, 1'b0);
      drain_results();

      // longest frame, then a runaway past the store and through the wrap
      configure(6'd63, 6'd5);
      set_idling(IDLE_RECEIVER);
      run_random(150, 1'b1, 1'b1);
      drain_results();

      configure(6'd12, 6'd12);
      set_idling(IDLE_BOTH);
      run_random(8, 1'b0, 1'b0);
      drain_results();

      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### fixed_length_frame_deframer.f
+incdir+src
src/flfd_pkg.sv
src/flfd_ifs.sv
src/flfd_csr.sv
src/flfd_ctrl.sv
src/flfd_dp.sv
src/fixed_length_frame_deframer.sv
tb/tb_top.sv
